FILE: design/sal_pkg.sv
// Shared types and constants for the set-associative LRU tag store.
`default_nettype none
package sal_pkg;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_FILL   = 2'd1,
        OP_SNOOP  = 2'd2,
        OP_INVAL  = 2'd3
    } t_op;

    typedef struct packed {
        logic [3:0] offset_width;
        logic [3:0] index_width;
    } t_cfg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX    = 1'd1;

    localparam int PORT_ADDR_W  = 48;
    localparam int PORT_STATE_W = 3;

endpackage
`default_nettype wire

FILE: design/set_assoc_lru_tag_store_top.sv
// Top level of the set-associative LRU tag store: configuration registers and the two halves.
`default_nettype none
// Tag array of a set-associative cache with true LRU order and a per-line coherence
// state. Requests transfer into a two-entry queue; the back end then takes one request at
// a time, first reading the set row from its RAM and then updating it, writing it back
// and loading the result register; the update waits while the result register is held
// by the downstream side. Each set row holds tags, states, valid and recent bits and the
// LRU order of all ways; a flip-flop per set marks rows written since reset, so no
// clearing pass is needed after reset.
module set_assoc_lru_tag_store_top #(
    parameter int WAYS = 4,
    parameter int MAX_SET_BITS = 8,
    parameter int ADDR_BITS = 48,
    parameter int STATE_BITS = 3
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_cfg_we,
    input  wire logic [sal_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  wire logic [sal_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    input  wire logic                                    i_valid,
    output logic                                         o_ready,
    input  wire logic [1:0]                              i_operation,
    input  wire logic [sal_pkg::PORT_ADDR_W-1:0]         i_address,
    input  wire logic [sal_pkg::PORT_STATE_W-1:0]        i_new_state,
    output logic                                         o_valid,
    input  wire logic                                    i_ready,
    output logic                                         o_found,
    output logic [sal_pkg::PORT_STATE_W-1:0]             o_line_state,
    output logic                                         o_was_recent,
    output logic                                         o_evicted,
    output logic [sal_pkg::PORT_ADDR_W-1:0]              o_victim_address
);
    import sal_pkg::*;

    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

    logic [3:0]            r_offset_width;
    logic [3:0]            r_index_width;
    t_cfg                  cfg;
    logic                  q_valid;
    logic                  q_pop;
    t_op                   q_op;
    logic [SET_W-1:0]      q_set;
    logic [ADDR_BITS-1:0]  q_tag;
    logic [STATE_BITS-1:0] q_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_width <= 4'd6;
            r_index_width  <= 4'd6;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BLOCK_OFFSET: r_offset_width <= i_cfg_data;
                CFG_SET_INDEX:    r_index_width  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Set bits beyond the array's depth saturate.
    assign cfg.offset_width = r_offset_width;
    assign cfg.index_width  = (r_index_width > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                                  : r_index_width;

    sal_front #(
        .MAX_SET_BITS(MAX_SET_BITS), .ADDR_BITS(ADDR_BITS), .STATE_BITS(STATE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_operation(i_operation),
        .i_address  (i_address),
        .i_new_state(i_new_state),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_op     (q_op),
        .o_q_set    (q_set),
        .o_q_tag    (q_tag),
        .o_q_state  (q_state)
    );

    sal_back #(
        .WAYS(WAYS), .MAX_SET_BITS(MAX_SET_BITS), .ADDR_BITS(ADDR_BITS),
        .STATE_BITS(STATE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_q_valid       (q_valid),
        .o_q_pop         (q_pop),
        .i_q_op          (q_op),
        .i_q_set         (q_set),
        .i_q_tag         (q_tag),
        .i_q_state       (q_state),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_found         (o_found),
        .o_line_state    (o_line_state),
        .o_was_recent    (o_was_recent),
        .o_evicted       (o_evicted),
        .o_victim_address(o_victim_address)
    );
endmodule
`default_nettype wire

FILE: design/sal_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: design/sal_front.sv
// Front end: accepts requests, splits the address into set and tag, and queues them.
`default_nettype none
module sal_front #(
    parameter int MAX_SET_BITS = 8,
    parameter int ADDR_BITS = 48,
    parameter int STATE_BITS = 3,
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire sal_pkg::t_cfg                           i_cfg,
    input  wire logic                                    i_valid,
    output logic                                         o_ready,
    input  wire logic [1:0]                              i_operation,
    input  wire logic [sal_pkg::PORT_ADDR_W-1:0]         i_address,
    input  wire logic [sal_pkg::PORT_STATE_W-1:0]        i_new_state,
    output logic                                         o_q_valid,
    input  wire logic                                    i_q_pop,
    output sal_pkg::t_op                                 o_q_op,
    output logic [SET_W-1:0]                             o_q_set,
    output logic [ADDR_BITS-1:0]                         o_q_tag,
    output logic [STATE_BITS-1:0]                        o_q_state
);
    import sal_pkg::*;

    logic [ADDR_BITS-1:0]  addr;
    logic [ADDR_BITS-1:0]  shifted;
    logic [SET_W-1:0]      idx_mask;
    logic                  push;

    t_op                   r_op    [2];
    logic [SET_W-1:0]      r_set   [2];
    logic [ADDR_BITS-1:0]  r_tag   [2];
    logic [STATE_BITS-1:0] r_state [2];
    logic                  r_wptr;
    logic                  r_rptr;
    logic [1:0]            r_count;

    assign addr     = ADDR_BITS'(i_address);
    assign shifted  = addr >> i_cfg.offset_width;
    assign idx_mask = ~({SET_W{1'b1}} << i_cfg.index_width);

    assign o_ready = (r_count != 2'd2);
    assign push    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_op[r_wptr]    <= t_op'(i_operation);
            r_set[r_wptr]   <= SET_W'(shifted) & idx_mask;
            r_tag[r_wptr]   <= shifted >> i_cfg.index_width;
            r_state[r_wptr] <= STATE_BITS'(i_new_state);
        end
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_q_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(push) - 2'(i_q_pop);
        end
    end

    assign o_q_valid = (r_count != 2'd0);
    assign o_q_op    = r_op[r_rptr];
    assign o_q_set   = r_set[r_rptr];
    assign o_q_tag   = r_tag[r_rptr];
    assign o_q_state = r_state[r_rptr];
endmodule
`default_nettype wire

FILE: design/sal_back.sv
// Back end: read-modify-write of one set row, LRU update and the result register.
`default_nettype none
module sal_back #(
    parameter int WAYS = 4,
    parameter int MAX_SET_BITS = 8,
    parameter int ADDR_BITS = 48,
    parameter int STATE_BITS = 3,
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire sal_pkg::t_cfg                           i_cfg,
    input  wire logic                                    i_q_valid,
    output logic                                         o_q_pop,
    input  wire sal_pkg::t_op                            i_q_op,
    input  wire logic [SET_W-1:0]                        i_q_set,
    input  wire logic [ADDR_BITS-1:0]                    i_q_tag,
    input  wire logic [STATE_BITS-1:0]                   i_q_state,
    output logic                                         o_valid,
    input  wire logic                                    i_ready,
    output logic                                         o_found,
    output logic [sal_pkg::PORT_STATE_W-1:0]             o_line_state,
    output logic                                         o_was_recent,
    output logic                                         o_evicted,
    output logic [sal_pkg::PORT_ADDR_W-1:0]              o_victim_address
);
    import sal_pkg::*;

    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NSETS = 1 << MAX_SET_BITS;
    localparam int OFS_V = 0;
    localparam int OFS_R = WAYS;
    localparam int OFS_S = 2 * WAYS;
    localparam int OFS_O = OFS_S + WAYS * STATE_BITS;
    localparam int OFS_T = OFS_O + WAYS * WW;
    localparam int ROW_W = OFS_T + WAYS * ADDR_BITS;

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state                r_st;
    t_op                   r_op;
    logic [SET_W-1:0]      r_set;
    logic [ADDR_BITS-1:0]  r_tag;
    logic [STATE_BITS-1:0] r_nst;
    logic                  r_row_ok;
    logic [NSETS-1:0]      r_row_init;

    logic                  r_out_valid;
    logic                  r_found;
    logic [PORT_STATE_W-1:0] r_line_state;
    logic                  r_was_recent;
    logic                  r_evicted;
    logic [PORT_ADDR_W-1:0]  r_victim;

    logic [ROW_W-1:0]      rd_row;
    logic [ROW_W-1:0]      wr_row;
    logic                  ram_re;
    logic                  commit;

    logic                  v   [WAYS];
    logic                  rc  [WAYS];
    logic [STATE_BITS-1:0] st  [WAYS];
    logic [WW-1:0]         ord [WAYS];
    logic [ADDR_BITS-1:0]  tg  [WAYS];

    logic                  nv   [WAYS];
    logic                  nrc  [WAYS];
    logic [STATE_BITS-1:0] nst  [WAYS];
    logic [WW-1:0]         nord [WAYS];
    logic [ADDR_BITS-1:0]  ntg  [WAYS];

    logic                  hit;
    logic [WW-1:0]         hpos;
    logic                  fre;
    logic [WW-1:0]         fpos;
    logic                  mru;
    logic [WW-1:0]         mpos;
    logic [WW-1:0]         hway;
    logic [WW-1:0]         fway;
    logic                  n_found;
    logic [PORT_STATE_W-1:0] n_line_state;
    logic                  n_was_recent;
    logic                  n_evicted;
    logic [PORT_ADDR_W-1:0]  n_victim;
    logic [ADDR_BITS-1:0]  base;

    sal_ram #(.WIDTH(ROW_W), .DEPTH(NSETS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (commit),
        .i_waddr(r_set[SET_W-1:0]),
        .i_wdata(wr_row),
        .i_re   (ram_re),
        .i_raddr(i_q_set),
        .o_rdata(rd_row)
    );

    assign ram_re  = (r_st == S_IDLE) && i_q_valid;
    assign o_q_pop = ram_re;
    assign commit  = (r_st == S_EXEC) && (!r_out_valid || i_ready);

    // A set row never written since reset reads as all invalid in identity order.
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            v[w]   = r_row_ok ? rd_row[OFS_V + w] : 1'b0;
            rc[w]  = r_row_ok ? rd_row[OFS_R + w] : 1'b0;
            st[w]  = rd_row[OFS_S + w * STATE_BITS +: STATE_BITS];
            ord[w] = r_row_ok ? rd_row[OFS_O + w * WW +: WW] : WW'(w);
            tg[w]  = rd_row[OFS_T + w * ADDR_BITS +: ADDR_BITS];
        end
    end

    always_comb begin
        hit  = 1'b0;
        hpos = '0;
        fre  = 1'b0;
        fpos = '0;
        for (int p = 0; p < WAYS; p++) begin
            if (!hit && v[ord[p]] && (tg[ord[p]] == r_tag)) begin
                hit  = 1'b1;
                hpos = WW'(p);
            end
            if (!fre && !v[ord[p]]) begin
                fre  = 1'b1;
                fpos = WW'(p);
            end
        end
    end

    assign hway = ord[hpos];
    assign fway = fre ? ord[fpos] : ord[0];
    assign base = ((tg[fway] << i_cfg.index_width) | ADDR_BITS'(r_set)) << i_cfg.offset_width;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            nv[w]  = v[w];
            nrc[w] = rc[w];
            nst[w] = st[w];
            ntg[w] = tg[w];
        end
        mru          = 1'b0;
        mpos         = hpos;
        n_found      = hit;
        n_line_state = hit ? PORT_STATE_W'(st[hway]) : '0;
        n_was_recent = 1'b0;
        n_evicted    = 1'b0;
        n_victim     = '0;
        case (r_op)
            OP_LOOKUP: begin
                mru = hit;
            end
            OP_FILL: begin
                mru = 1'b1;
                if (hit) begin
                    nrc[hway] = 1'b1;
                    nst[hway] = r_nst;
                end else begin
                    mpos       = fre ? fpos : '0;
                    nrc[fway]  = 1'b1;
                    nst[fway]  = r_nst;
                    ntg[fway]  = r_tag;
                    nv[fway]   = 1'b1;
                    n_evicted  = !fre;
                    n_victim   = fre ? '0 : PORT_ADDR_W'(base);
                end
            end
            OP_SNOOP: begin
                if (hit) begin
                    nst[hway]    = r_nst;
                    n_was_recent = rc[hway];
                    nrc[hway]    = 1'b0;
                end
            end
            default: begin
                if (hit) begin
                    nv[hway] = 1'b0;
                end
            end
        endcase
    end

    // Moving a way to the MRU end shifts every later position down by one.
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            nord[i] = ord[i];
        end
        if (mru) begin
            for (int i = 0; i < WAYS - 1; i++) begin
                if (WW'(i) >= mpos) begin
                    nord[i] = ord[i + 1];
                end
            end
            nord[WAYS-1] = ord[mpos];
        end
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            wr_row[OFS_V + w]                             = nv[w];
            wr_row[OFS_R + w]                             = nrc[w];
            wr_row[OFS_S + w * STATE_BITS +: STATE_BITS]  = nst[w];
            wr_row[OFS_O + w * WW +: WW]                  = nord[w];
            wr_row[OFS_T + w * ADDR_BITS +: ADDR_BITS]    = ntg[w];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_op     <= i_q_op;
            r_set    <= i_q_set;
            r_tag    <= i_q_tag;
            r_nst    <= i_q_state;
            r_row_ok <= r_row_init[i_q_set];
        end
        if (commit) begin
            r_found      <= n_found;
            r_line_state <= n_line_state;
            r_was_recent <= n_was_recent;
            r_evicted    <= n_evicted;
            r_victim     <= n_victim;
        end
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_out_valid <= 1'b0;
            r_row_init  <= '0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (ram_re) begin
                        r_st <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (commit) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
            if (commit) begin
                r_out_valid       <= 1'b1;
                r_row_init[r_set] <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_found          = r_found;
    assign o_line_state     = r_line_state;
    assign o_was_recent     = r_was_recent;
    assign o_evicted        = r_evicted;
    assign o_victim_address = r_victim;

    a_evict_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evicted |-> !o_found)
        else $error("eviction reported together with a hit");

    a_recent_is_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_recent |-> o_found)
        else $error("recent mark reported for a miss");

    a_pop_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_st == S_EXEC)
        else $error("queue pop did not start a set update");
endmodule
`default_nettype wire

FILE: test/sal_checker.sv
// Checker for the LRU tag store: predicts each request's result and compares transfers.
module sal_checker #(
    parameter int WAYS = 4,
    parameter int MAX_SET_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [3:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [47:0] i_address,
    input  wire logic [2:0]  i_new_state,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic        i_found,
    input  wire logic [2:0]  i_line_state,
    input  wire logic        i_was_recent,
    input  wire logic        i_evicted,
    input  wire logic [47:0] i_victim_address,
    output int               o_errors,
    output int               o_pending
);
    import sal_pkg::*;

    localparam int NSETS = 1 << MAX_SET_BITS;

    typedef struct packed {
        logic        found;
        logic [2:0]  line_state;
        logic        was_recent;
        logic        evicted;
        logic [47:0] victim_address;
    } t_lookup_res;

    logic [3:0]  offset_width;
    logic [3:0]  index_width;
    logic        line_valid [NSETS][WAYS];
    logic [63:0] line_tag   [NSETS][WAYS];
    logic [2:0]  line_st    [NSETS][WAYS];
    logic        line_mru   [NSETS][WAYS];
    int          way_order  [NSETS][WAYS];
    t_lookup_res expected_results [$];

    assign o_pending = expected_results.size();

    task automatic clear_tags();
        offset_width = 4'd6;
        index_width  = 4'd6;
        for (int s = 0; s < NSETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
                line_valid[s][w] = 1'b0;
                line_tag[s][w]   = '0;
                line_st[s][w]    = '0;
                line_mru[s][w]   = 1'b0;
                way_order[s][w]  = w;
            end
        end
    endtask

    // Moves the way at order position pos to the most recently used end.
    function automatic void promote(int set, int pos);
        int w;
        w = way_order[set][pos];
        for (int i = pos; i < WAYS - 1; i++) way_order[set][i] = way_order[set][i + 1];
        way_order[set][WAYS - 1] = w;
    endfunction

    function automatic t_lookup_res tag_access(t_op op, logic [47:0] addr, logic [2:0] nst);
        t_lookup_res r;
        int sb, bb, set, pos, way, vpos;
        logic [63:0] shifted, tag, base;
        bit free_found;
        r = '0;
        sb = (index_width > MAX_SET_BITS) ? MAX_SET_BITS : int'(index_width);
        bb = int'(offset_width);
        shifted = 64'(addr) >> bb;
        set = int'(shifted & ((64'd1 << sb) - 1));
        tag = shifted >> sb;
        pos = WAYS;
        for (int p = WAYS - 1; p >= 0; p--) begin
            way = way_order[set][p];
            if (line_valid[set][way] && line_tag[set][way] == tag) pos = p;
        end
        way = (pos < WAYS) ? way_order[set][pos] : 0;
        if (pos < WAYS) begin
            r.found = 1'b1;
            r.line_state = line_st[set][way];
        end
        case (op)
            OP_LOOKUP: if (pos < WAYS) promote(set, pos);
            OP_FILL: begin
                if (pos < WAYS) begin
                    promote(set, pos);
                    line_mru[set][way] = 1'b1;
                    line_st[set][way] = nst;
                end else begin
                    vpos = 0;
                    free_found = 0;
                    for (int p = 0; p < WAYS; p++) begin
                        if (!free_found && !line_valid[set][way_order[set][p]]) begin
                            vpos = p;
                            free_found = 1;
                        end
                    end
                    way = way_order[set][vpos];
                    if (!free_found) begin
                        base = ((line_tag[set][way] << sb) | 64'(set)) << bb;
                        r.evicted = 1'b1;
                        r.victim_address = base[47:0];
                    end
                    line_mru[set][way] = 1'b1;
                    line_tag[set][way] = tag;
                    line_st[set][way] = nst;
                    line_valid[set][way] = 1'b1;
                    promote(set, vpos);
                end
            end
            OP_SNOOP: if (pos < WAYS) begin
                line_st[set][way] = nst;
                r.was_recent = line_mru[set][way];
                line_mru[set][way] = 1'b0;
            end
            default: if (pos < WAYS) line_valid[set][way] = 1'b0;
        endcase
        return r;
    endfunction

    initial begin
        o_errors = 0;
        clear_tags();
    end

    always @(posedge i_clk) begin
        t_lookup_res exp_r;
        if (!i_rst_n) begin
            clear_tags();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_BLOCK_OFFSET) offset_width = i_cfg_data;
                else index_width = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    o_errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_found !== exp_r.found) begin
                        $error("found: expected %0h, got %0h", exp_r.found, i_found);
                        o_errors++;
                    end
                    if (i_line_state !== exp_r.line_state) begin
                        $error("line_state: expected %0h, got %0h",
                               exp_r.line_state, i_line_state);
                        o_errors++;
                    end
                    if (i_was_recent !== exp_r.was_recent) begin
                        $error("was_recent: expected %0h, got %0h",
                               exp_r.was_recent, i_was_recent);
                        o_errors++;
                    end
                    if (i_evicted !== exp_r.evicted) begin
                        $error("evicted: expected %0h, got %0h", exp_r.evicted, i_evicted);
                        o_errors++;
                    end
                    if (i_victim_address !== exp_r.victim_address) begin
                        $error("victim_address: expected %0h, got %0h",
                               exp_r.victim_address, i_victim_address);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(tag_access(t_op'(i_operation), i_address,
                                                      i_new_state));
        end
    end
endmodule

FILE: test/tb.sv
// Testbench top for the LRU tag store: clock, reset, stimulus, watchdog and verdict.
module tb;
    import sal_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_operation;
    logic [47:0] i_address;
    logic [2:0]  i_new_state;
    logic        o_valid;
    logic        i_ready;
    logic        o_found;
    logic [2:0]  o_line_state;
    logic        o_was_recent;
    logic        o_evicted;
    logic [47:0] o_victim_address;
    int          errors;
    int          pending;
    int          idle_cycles;
    int          cur_block;
    int          cur_sets;

    set_assoc_lru_tag_store_top dut (.*);

    sal_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_operation(i_operation), .i_address(i_address), .i_new_state(i_new_state),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_found(o_found),
        .i_line_state(o_line_state), .i_was_recent(o_was_recent), .i_evicted(o_evicted),
        .i_victim_address(o_victim_address), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Builds an address from a tag, a set and an offset under the current layout.
    function automatic logic [47:0] compose_addr(logic [47:0] tag, int set);
        int sb;
        logic [63:0] a;
        sb = (cur_sets > 8) ? 8 : cur_sets;
        a = ((64'(tag) << sb) | 64'(set & ((1 << sb) - 1))) << cur_block;
        a = a | (64'($urandom()) & ((64'd1 << cur_block) - 1));
        return a[47:0];
    endfunction

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic send_req(t_op op, logic [47:0] addr, logic [2:0] st);
        int gap;
        i_valid     <= 1'b1;
        i_operation <= op;
        i_address   <= addr;
        i_new_state <= st;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid     <= 1'b0;
            i_operation <= 2'($urandom());
            i_address   <= 48'({$urandom(), $urandom()});
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic set_layout(int bb, int sb);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BLOCK_OFFSET;
        i_cfg_data  <= 4'(bb);
        @(negedge i_clk);
        i_cfg_index <= CFG_SET_INDEX;
        i_cfg_data  <= 4'(sb);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_block = bb;
        cur_sets = sb;
    endtask

    task automatic random_phase(int count);
        logic [47:0] tag;
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send_req(t_op'($urandom_range(0, 3)), 48'({$urandom(), $urandom()}),
                         3'($urandom()));
            end else begin
                tag = ($urandom_range(0, 9) == 0) ? 48'({$urandom(), $urandom()})
                                                   : 48'($urandom_range(0, 6));
                send_req(t_op'($urandom_range(0, 3)),
                         compose_addr(tag, $urandom_range(0, 2)), 3'($urandom()));
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off so the request side backs up.
    initial begin
        int cyc;
        int gap;
        bit long_done;
        i_ready = 1'b0;
        cyc = 0;
        long_done = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (!long_done && cyc >= 1500) begin
                long_done = 1'b1;
                i_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                cyc += 300;
            end else if ($urandom_range(0, 99) < 30) begin
                gap = pick_gap();
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                    cyc += gap;
                end
            end
            i_ready <= 1'b1;
        end
    end

    // Watchdog: too long without any transfer on either side ends the run.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= 5000) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_operation = '0;
        i_address   = '0;
        i_new_state = '0;
        cur_block   = 6;
        cur_sets    = 6;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes of address and state, every operation, misses,
        // eviction from a full set and snoop of a line with and without its mark.
        send_req(OP_LOOKUP, 48'h0, 3'd0);
        send_req(OP_FILL, 48'h0, 3'd7);
        send_req(OP_FILL, 48'hFFFF_FFFF_FFFF, 3'd0);
        send_req(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 3'd0);
        send_req(OP_SNOOP, 48'h0, 3'd5);
        send_req(OP_SNOOP, 48'h0, 3'd2);
        send_req(OP_LOOKUP, 48'h0, 3'd0);
        for (int t = 1; t <= 5; t++) send_req(OP_FILL, compose_addr(48'(t), 1), 3'(t));
        send_req(OP_LOOKUP, compose_addr(48'd2, 1), 3'd0);
        send_req(OP_FILL, compose_addr(48'd6, 1), 3'd6);
        send_req(OP_INVAL, compose_addr(48'd4, 1), 3'd0);
        send_req(OP_INVAL, compose_addr(48'd4, 1), 3'd0);
        send_req(OP_FILL, compose_addr(48'd7, 1), 3'd1);
        send_req(OP_FILL, compose_addr(48'd7, 1), 3'd3);
        send_req(OP_SNOOP, compose_addr(48'd9, 1), 3'd3);
        send_req(OP_INVAL, 48'hFFFF_FFFF_FFFF, 3'd0);

        random_phase(170);
        set_layout(0, 0);
        random_phase(170);
        set_layout(12, 8);
        random_phase(170);
        set_layout(15, 15);
        random_phase(170);
        set_layout(3, 2);
        random_phase(170);
        set_layout(4, 9);
        random_phase(170);

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
